/* src/bfdh_pkg.sv */
// shared types and constants for the bloom filter double hash unit
// no dependencies

package bfdh_pkg;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_DIV,
    ST_READ,
    ST_TEST,
    ST_DONE
  } state_t;

  localparam logic [1:0] REG_KEY_COUNT   = 2'd0;
  localparam logic [1:0] REG_KEY_BITS    = 2'd1;
  localparam logic [1:0] REG_PROBE_COUNT = 2'd2;

  localparam int CFG_W     = 14;
  localparam int KEY_W     = 14;
  localparam int BPK_W     = 7;
  localparam int PROBE_W   = 8;
  localparam int HASH_W    = 32;
  localparam int INDEX_W   = 10;
  localparam int PROD_W    = KEY_W + BPK_W;
  localparam int MIN_BITS  = 64;
  localparam int ROT_RIGHT = 17;

  localparam logic [KEY_W-1:0]   KEY_COUNT_RST   = 14'd0;
  localparam logic [BPK_W-1:0]   KEY_BITS_RST    = 7'd10;
  localparam logic [PROBE_W-1:0] PROBE_COUNT_RST = 8'd6;

  // delta for double hashing: rotate right
  function automatic logic [HASH_W-1:0] rotate_delta(input logic [HASH_W-1:0] h);
    rotate_delta = (h >> ROT_RIGHT) | (h << (HASH_W - ROT_RIGHT));
  endfunction

endpackage

/* src/bfdh_ram.sv */
// generic simple dual-port ram, one write port, one registered read port
// no dependencies

module bfdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/bfdh_mod.sv */
// iterative 32-bit modulo, one dividend bit per cycle (restoring)
// uses bfdh_pkg for the hash width

module bfdh_mod
  import bfdh_pkg::*;
#(
  parameter int DIVISOR_W = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [HASH_W-1:0]    dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 done,
  output logic [DIVISOR_W-1:0] remainder
);

  localparam int CNT_W = $clog2(HASH_W);

  logic                 busy;
  logic [CNT_W-1:0]     count;
  logic [HASH_W-1:0]    dvd;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   reduced;

  // remainder stays below the divisor, so one compare and subtract per bit
  always_comb begin
    shifted = {remainder, dvd[HASH_W-1]};
    if (shifted >= {1'b0, dvs}) begin
      reduced = shifted - {1'b0, dvs};
    end else begin
      reduced = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_W'(HASH_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      dvd       <= dvd << 1;
      remainder <= reduced[DIVISOR_W-1:0];
    end
  end

endmodule

/* src/bloom_filter_double_hash_unit.sv */
// bloom filter with double hashing over a byte-wide bit store
// depends on bfdh_pkg, bfdh_ram and bfdh_mod
//
// usage: items arrive on in_valid/in_ready with kind, key_hash and byte_index;
// one result beat per item leaves on out_valid/out_ready with may_match and
// filter_byte. configuration goes through cfg_we/cfg_index/cfg_data; the
// user must keep it written only while the unit is idle; the unit does not enforce this.
// one item is handled at a time. work per item, from accept to result:
//   clear  : one store byte zeroed per cycle, over all FILTER_BYTES
//   insert : k probes, k = probe count clamped to 1..MAX_PROBES
//   query  : up to probe_count probes, stops at the first clear bit;
//            no probe when probe_count is zero or above MAX_PROBES
//   read   : one store byte read at byte_index
// each probe costs a bit-serial modulo plus a read-modify-write on
// the single store ram; the modulo unit sets the rate.
// reset: rst is synchronous; afterwards a clearing pass over all FILTER_BYTES
// zeroes the store, with in_ready low (config writes are still taken).
// the result sits in an output register; the next item is taken while it
// waits, and a new result holds until the receiver has taken the old one.

module bloom_filter_double_hash_unit
  import bfdh_pkg::*;
#(
  parameter int FILTER_BYTES = 1024,
  parameter int MAX_PROBES   = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic [HASH_W-1:0]  key_hash,
  input  logic [INDEX_W-1:0] byte_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               may_match,
  output logic [7:0]         filter_byte,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int AW     = $clog2(FILTER_BYTES);
  localparam int SB_W   = $clog2(FILTER_BYTES + 1);
  localparam int BITS_W = SB_W + 3;
  localparam int PW     = $clog2(MAX_PROBES + 1);
  localparam int SZ_W   = PROD_W + 1;

  localparam logic [SB_W-1:0] FB_SAT     = SB_W'(FILTER_BYTES);
  localparam logic [AW-1:0]   LAST_ADDR  = AW'(FILTER_BYTES - 1);
  localparam logic [PROBE_W-1:0] PMAX    = PROBE_W'(MAX_PROBES);

  // configuration
  logic [KEY_W-1:0]   key_count;
  logic [BPK_W-1:0]   key_bits;
  logic [PROBE_W-1:0] probe_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count   <= KEY_COUNT_RST;
      key_bits    <= KEY_BITS_RST;
      probe_count <= PROBE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_COUNT:   key_count   <= cfg_data[KEY_W-1:0];
        REG_KEY_BITS:    key_bits    <= cfg_data[BPK_W-1:0];
        REG_PROBE_COUNT: probe_count <= cfg_data[PROBE_W-1:0];
        default: ;
      endcase
    end
  end

  // filter size in bits
  logic [PROD_W-1:0] size_prod;
  logic [SZ_W-1:0]   size_bits;
  logic [SZ_W-1:0]   size_bytes;
  logic [SB_W-1:0]   sat_bytes;
  logic [BITS_W-1:0] bits_cfg;

  always_comb begin
    size_prod = PROD_W'(key_count) * PROD_W'(key_bits);
    if (size_prod < PROD_W'(MIN_BITS)) begin
      size_bits = SZ_W'(MIN_BITS);
    end else begin
      size_bits = SZ_W'(size_prod);
    end
    size_bytes = (size_bits + SZ_W'(7)) >> 3;
    if (32'(size_bytes) > 32'(FILTER_BYTES)) begin
      sat_bytes = FB_SAT;
    end else begin
      sat_bytes = SB_W'(size_bytes);
    end
    bits_cfg = {sat_bytes, 3'b000};
  end

  // probe count per kind
  logic [PROBE_W-1:0] ins_clamp;
  logic               query_trivial;

  always_comb begin
    if (probe_count == '0) begin
      ins_clamp = PROBE_W'(1);
    end else if (probe_count > PMAX) begin
      ins_clamp = PMAX;
    end else begin
      ins_clamp = probe_count;
    end
    query_trivial = (probe_count == '0) || (probe_count > PMAX);
  end

  // working registers
  state_t            state, state_next;
  kind_t             kind_reg;
  logic [HASH_W-1:0] h;
  logic [HASH_W-1:0] delta;
  logic [BITS_W-1:0] bits_reg;
  logic [BITS_W-1:0] pos;
  logic [PW-1:0]     probe_idx;
  logic [PW-1:0]     probe_total;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     read_addr;
  logic              read_ok;
  logic              res_match;
  logic [7:0]        res_byte;

  // modulo unit
  logic              div_start;
  logic [HASH_W-1:0] div_dividend;
  logic [BITS_W-1:0] div_divisor;
  logic              div_done;
  logic [BITS_W-1:0] div_rem;

  bfdh_mod #(
    .DIVISOR_W(BITS_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .remainder(div_rem)
  );

  // store
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  bfdh_ram #(
    .WIDTH(8),
    .DEPTH(FILTER_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  logic [31:0] pos_byte32;
  logic [31:0] idx32;
  logic [7:0]  bit_mask;
  logic        bit_set;
  logic        in_acc;
  logic        out_load;
  logic        last_probe;
  logic        next_probe;

  always_comb begin
    pos_byte32 = 32'(pos >> 3);
    idx32      = 32'(byte_index);
    bit_mask   = 8'd1 << pos[2:0];
    bit_set    = (ram_rdata & bit_mask) != 8'd0;
    last_probe = (PW'(probe_idx + 1'b1) == probe_total);
    in_ready   = (state == ST_IDLE);
    in_acc     = in_valid && in_ready;
  end

  // sequencer; probes never overlap, so the read-modify-write needs no forwarding
  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = key_hash;
    div_divisor  = bits_cfg;
    ram_we       = 1'b0;
    ram_waddr    = clr_addr;
    ram_wdata    = 8'd0;
    ram_raddr    = pos_byte32[AW-1:0];
    out_load     = 1'b0;
    next_probe   = 1'b0;
    unique case (state)
      ST_INIT: begin
        ram_we = 1'b1;
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (kind_t'(kind))
            KIND_CLEAR:  state_next = ST_CLEAR;
            KIND_INSERT: begin
              div_start  = 1'b1;
              state_next = ST_DIV;
            end
            KIND_QUERY: begin
              if (query_trivial) begin
                state_next = ST_DONE;
              end else begin
                div_start  = 1'b1;
                state_next = ST_DIV;
              end
            end
            KIND_READ:   state_next = ST_READ;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (kind_reg == KIND_READ) begin
          ram_raddr = read_addr;
        end
        state_next = ST_TEST;
      end
      ST_TEST: begin
        if (kind_reg == KIND_READ) begin
          state_next = ST_DONE;
        end else begin
          if (kind_reg == KIND_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = pos_byte32[AW-1:0];
            ram_wdata = ram_rdata | bit_mask;
          end
          if (last_probe || (kind_reg == KIND_QUERY && !bit_set)) begin
            state_next = ST_DONE;
          end else begin
            next_probe   = 1'b1;
            div_start    = 1'b1;
            div_dividend = h + delta;
            div_divisor  = bits_reg;
            state_next   = ST_DIV;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_INIT || state == ST_CLEAR) begin
        clr_addr <= (clr_addr == LAST_ADDR) ? '0 : clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_reg    <= kind_t'(kind);
      h           <= key_hash;
      delta       <= rotate_delta(key_hash);
      bits_reg    <= bits_cfg;
      probe_idx   <= '0;
      read_addr   <= idx32[AW-1:0];
      read_ok     <= idx32 < 32'(FILTER_BYTES);
      res_byte    <= 8'd0;
      res_match   <= (kind_t'(kind) == KIND_QUERY);
      probe_total <= (kind_t'(kind) == KIND_INSERT) ? PW'(ins_clamp) : PW'(probe_count);
    end else begin
      if (state == ST_DIV && div_done) begin
        pos <= div_rem;
      end
      if (state == ST_TEST) begin
        if (kind_reg == KIND_READ) begin
          res_byte <= read_ok ? ram_rdata : 8'd0;
        end else if (kind_reg == KIND_QUERY && !bit_set) begin
          res_match <= 1'b0;
        end
      end
      if (next_probe) begin
        h         <= h + delta;
        probe_idx <= probe_idx + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      may_match   <= res_match;
      filter_byte <= res_byte;
    end
  end

  // checks
  a_we_legal: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_INIT || state == ST_CLEAR ||
                (state == ST_TEST && kind_reg == KIND_INSERT)))
    else $error("store written outside clear or insert");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("modulo finished outside a probe");

  a_fields_exclusive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && filter_byte != 8'd0) |-> !may_match)
    else $error("result beat carries both a byte and a match");

  a_no_accept_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !in_ready)
    else $error("item taken before the store was cleared");

  a_load_only_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

endmodule
